// File: src/tcce_pkg.sv
// Shared constants, types and helpers for the text console character engine.
`default_nettype none

package tcce_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int CELL_AW = $clog2(CELLS);

    // Fixed field widths
    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;

    localparam int IN_TDATA_W  = 24;  // char_code, cell_index, pad
    localparam int OUT_TDATA_W = 40;  // serial_byte, cursor_pos, cell_value, pad

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

    // Datapath operations issued by the controller, one per cycle
    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_INIT      = 4'd1,
        OP_CLR       = 4'd2,
        OP_PUT       = 4'd3,
        OP_SCRL_RD   = 4'd4,
        OP_SCRL_WR   = 4'd5,
        OP_BLANK     = 4'd6,
        OP_CELL_RD   = 4'd7,
        OP_EMIT_MAIN = 4'd8,
        OP_EMIT_CR   = 4'd9
    } t_dp_op;

    typedef struct packed {
        logic   load;  // capture the input item
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic at_end;       // sweep address on the last cell
        logic at_move_end;  // sweep address on the last cell that scroll moves
        logic put_scroll;   // the pending put leaves the bottom row
        logic nl_put;       // the held item is a newline put
        logic out_free;     // output register can take a result
    } t_sts;

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return CELL_AW'(row) * CELL_AW'(COLUMNS) + CELL_AW'(col);
    endfunction

endpackage

`default_nettype wire

// File: src/tcce_ram.sv
// Generic one-write, one-read RAM with registered read data.
`default_nettype none

module tcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/tcce_ctrl.sv
// Controller state machine for the text console character engine.
`default_nettype none

module tcce_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [tcce_pkg::KIND_W-1:0]  i_kind,
    output logic                              o_ready,
    input  wire tcce_pkg::t_sts               i_sts,
    output tcce_pkg::t_cmd                    o_cmd
);
    import tcce_pkg::*;

    typedef enum logic [9:0] {
        S_INIT    = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_PUT     = 10'b00_0000_0100,
        S_SCRL_RD = 10'b00_0000_1000,
        S_SCRL_WR = 10'b00_0001_0000,
        S_BLANK   = 10'b00_0010_0000,
        S_CLEAR   = 10'b00_0100_0000,
        S_READ    = 10'b00_1000_0000,
        S_EMIT    = 10'b01_0000_0000,
        S_EMIT_CR = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = o_ready && i_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.op   = OP_NOP;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = OP_INIT;
                if (i_sts.at_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (i_kind)
                        KIND_PUT:   n_state = S_PUT;
                        KIND_CLEAR: n_state = S_CLEAR;
                        KIND_READ:  n_state = S_READ;
                        default:    n_state = S_EMIT;
                    endcase
                end
            end
            S_PUT: begin
                o_cmd.op = OP_PUT;
                n_state  = i_sts.put_scroll ? S_SCRL_RD : S_EMIT;
            end
            S_SCRL_RD: begin
                o_cmd.op = OP_SCRL_RD;
                n_state  = S_SCRL_WR;
            end
            S_SCRL_WR: begin
                o_cmd.op = OP_SCRL_WR;
                n_state  = i_sts.at_move_end ? S_BLANK : S_SCRL_RD;
            end
            S_BLANK: begin
                o_cmd.op = OP_BLANK;
                if (i_sts.at_end) n_state = S_EMIT;
            end
            S_CLEAR: begin
                o_cmd.op = OP_CLR;
                if (i_sts.at_end) n_state = S_EMIT;
            end
            S_READ: begin
                o_cmd.op = OP_CELL_RD;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT_MAIN;
                    n_state  = i_sts.nl_put ? S_EMIT_CR : S_IDLE;
                end
            end
            S_EMIT_CR: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT_CR;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: src/tcce_dp.sv
// Datapath: screen store, cursor, attribute register, sweep counter, result register.
`default_nettype none

module tcce_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tcce_pkg::t_cmd               i_cmd,
    output tcce_pkg::t_sts                    o_sts,
    input  wire logic [tcce_pkg::KIND_W-1:0]  i_kind,
    input  wire logic [tcce_pkg::CHAR_W-1:0]  i_char,
    input  wire logic [tcce_pkg::POS_W-1:0]   i_idx,
    input  wire logic                         i_cfg_we,
    input  wire logic [tcce_pkg::ATTR_W-1:0]  i_cfg_attr,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [tcce_pkg::CHAR_W-1:0]       o_serial_byte,
    output logic                              o_serial_valid,
    output logic [tcce_pkg::POS_W-1:0]        o_cursor_pos,
    output logic [tcce_pkg::CELL_W-1:0]       o_cell_value,
    output logic                              o_last
);
    import tcce_pkg::*;

    // Item and control registers
    logic [KIND_W-1:0]  r_kind;
    logic [CHAR_W-1:0]  r_char;
    logic [POS_W-1:0]   r_idx;
    logic [ATTR_W-1:0]  r_attr;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [CELL_AW-1:0] r_addr, n_addr;

    // Result register
    logic               r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]  r_obyte, n_obyte;
    logic               r_osv, n_osv;
    logic [POS_W-1:0]   r_opos, n_opos;
    logic [CELL_W-1:0]  r_ocell, n_ocell;
    logic               r_olast, n_olast;

    // Memory port
    logic               ram_we, ram_re;
    logic [CELL_AW-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    logic [CELL_AW-1:0] lin;
    logic [COL_W-1:0]   col_dec;
    logic [CELL_W-1:0]  blank_cell;
    logic               is_nl, is_bs, row_last, col_last, in_range, out_free;

    assign lin        = cell_addr(r_row, r_col);
    assign col_dec    = (r_col != '0) ? r_col - COL_W'(1) : r_col;
    assign blank_cell = {r_attr, CH_SPACE};
    assign is_nl      = (r_char == CH_NEWLINE);
    assign is_bs      = (r_char == CH_BACKSPACE);
    assign row_last   = (r_row == ROW_W'(ROWS - 1));
    assign col_last   = (r_col == COL_W'(COLUMNS - 1));
    assign in_range   = (32'(r_idx) < 32'(CELLS));
    assign out_free   = !r_ovalid || i_out_ready;

    assign o_sts.at_end      = (r_addr == CELL_AW'(CELLS - 1));
    assign o_sts.at_move_end = (r_addr == CELL_AW'(CELLS - COLUMNS - 1));
    assign o_sts.put_scroll  = row_last && (is_nl || (!is_bs && col_last));
    assign o_sts.nl_put      = (r_kind == KIND_PUT) && is_nl;
    assign o_sts.out_free    = out_free;

    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_addr    = r_addr;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = blank_cell;
        ram_re    = 1'b0;
        ram_raddr = CELL_AW'(r_idx);
        n_ovalid  = r_ovalid && !i_out_ready;
        n_obyte   = r_obyte;
        n_osv     = r_osv;
        n_opos    = r_opos;
        n_ocell   = r_ocell;
        n_olast   = r_olast;

        if (i_cmd.load) n_addr = '0;

        case (i_cmd.op)
            OP_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = RESET_CELL;
                n_addr    = r_addr + CELL_AW'(1);
            end
            OP_CLR: begin
                ram_we = 1'b1;
                n_addr = r_addr + CELL_AW'(1);
                n_row  = '0;
                n_col  = '0;
            end
            OP_PUT: begin
                if (is_nl) begin
                    n_col = '0;
                    if (!row_last) n_row = r_row + ROW_W'(1);
                end else if (is_bs) begin
                    n_col     = col_dec;
                    ram_we    = 1'b1;
                    ram_waddr = cell_addr(r_row, col_dec);
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = lin;
                    ram_wdata = {r_attr, r_char};
                    if (col_last) begin
                        n_col = '0;
                        if (!row_last) n_row = r_row + ROW_W'(1);
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            end
            OP_SCRL_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_addr + CELL_AW'(COLUMNS);
            end
            OP_SCRL_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_addr    = r_addr + CELL_AW'(1);
            end
            OP_BLANK: begin
                ram_we = 1'b1;
                n_addr = r_addr + CELL_AW'(1);
            end
            OP_CELL_RD: begin
                ram_re = 1'b1;
            end
            OP_EMIT_MAIN: begin
                n_ovalid = 1'b1;
                n_opos   = POS_W'(lin);
                if (r_kind == KIND_PUT) begin
                    n_obyte = r_char;
                    n_osv   = 1'b1;
                    n_ocell = '0;
                    n_olast = !is_nl;
                end else begin
                    n_obyte = '0;
                    n_osv   = 1'b0;
                    n_ocell = ((r_kind == KIND_READ) && in_range) ? ram_rdata : '0;
                    n_olast = 1'b1;
                end
            end
            OP_EMIT_CR: begin
                n_ovalid = 1'b1;
                n_opos   = POS_W'(lin);
                n_obyte  = CH_RETURN;
                n_osv    = 1'b1;
                n_ocell  = '0;
                n_olast  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr   <= RESET_ATTR;
            r_row    <= '0;
            r_col    <= '0;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_attr <= i_cfg_attr;
            r_row    <= n_row;
            r_col    <= n_col;
            r_addr   <= n_addr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_char <= i_char;
            r_idx  <= i_idx;
        end
        r_obyte <= n_obyte;
        r_osv   <= n_osv;
        r_opos  <= n_opos;
        r_ocell <= n_ocell;
        r_olast <= n_olast;
    end

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid    = r_ovalid;
    assign o_serial_byte  = r_obyte;
    assign o_serial_valid = r_osv;
    assign o_cursor_pos   = r_opos;
    assign o_cell_value   = r_ocell;
    assign o_last         = r_olast;

endmodule

`default_nettype wire

// File: src/text_console_character_engine.sv
// Top level of the text console character engine.
`default_nettype none

// Text console character engine. Keeps a ROWS x COLUMNS screen of 16-bit
// cells (attribute in the high byte, character in the low byte) and a
// cursor. Each input transaction is a put (echo the byte, then newline,
// backspace or store-and-advance, wrapping at the last column and scrolling
// at the last row), a clear (blank the screen with the current attribute
// and home the cursor) or a read of one cell. Every result carries the
// cursor position after the item; a newline put gives two results, the
// newline and then a carriage return, the rest give one. Timing is set by
// the single screen RAM, which does one write and one registered read per
// cycle. A put or a read is accepted in the idle state, does its work in
// S_PUT or S_READ and loads the result in S_EMIT, then returns to idle
// for the next transaction. A newline adds S_EMIT_CR for the carriage
// return. A clear adds a blanking sweep over all CELLS (2000) cells, and
// a put that scrolls adds a sweep in which every moved cell is read and
// then written and the bottom row is blanked. A stalled result holds the
// next result in S_EMIT or S_EMIT_CR until tready frees the output
// register. After reset the engine fills all CELLS (2000) cells of the
// screen with blank cells, attribute 0x07, and
// takes no input transaction until then; configuration writes are taken
// at any time. Write the attribute register only while the engine is idle.
// A finished result waits in the output register while the next item is
// accepted.
module text_console_character_engine (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input stream
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // [7:0] char_code, [18:8] cell_index, [23:19] zero
    input  wire logic [tcce_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // [1:0] kind
    input  wire logic [tcce_pkg::KIND_W-1:0]       i_s_axis_tuser,
    // Result stream
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [7:0] serial_byte, [18:8] cursor_pos, [34:19] cell_value, [39:35] zero
    output logic [tcce_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // [0] serial_valid
    output logic [0:0]                             o_m_axis_tuser,
    output logic                                   o_m_axis_tlast,
    // Attribute register write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tcce_pkg::ATTR_W-1:0]       i_cfg_data
);
    import tcce_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic [CHAR_W-1:0] serial_byte;
    logic              serial_valid;
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_value;

    // The attribute register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    tcce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_kind  (i_s_axis_tuser),
        .o_ready (o_s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tcce_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_s_axis_tuser),
        .i_char         (i_s_axis_tdata[CHAR_W-1:0]),
        .i_idx          (i_s_axis_tdata[CHAR_W +: POS_W]),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_attr     (i_cfg_data),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_serial_byte  (serial_byte),
        .o_serial_valid (serial_valid),
        .o_cursor_pos   (cursor_pos),
        .o_cell_value   (cell_value),
        .o_last         (o_m_axis_tlast)
    );

    // Pack the result fields, first field in the low bits.
    assign o_m_axis_tdata = OUT_TDATA_W'({cell_value, cursor_pos, serial_byte});
    assign o_m_axis_tuser = serial_valid;

endmodule

`default_nettype wire

// File: src/tcce_chk.sv
// Port-level checker for the text console character engine, with its bind.
`default_nettype none

module tcce_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_s_axis_tready,
    input wire logic                              o_m_axis_tvalid,
    input wire logic                              i_m_axis_tready,
    input wire logic [tcce_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input wire logic [0:0]                        o_m_axis_tuser,
    input wire logic                              o_m_axis_tlast
);
    import tcce_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // Only a newline echo is followed by a second result.
    a_first_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |->
            o_m_axis_tuser[0] && (o_m_axis_tdata[7:0] == CH_NEWLINE))
        else $error("non-final result is not a newline echo");

    // The carriage return follows the newline in the next cycle.
    a_cr_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid && o_m_axis_tlast && (o_m_axis_tdata[7:0] == CH_RETURN))
        else $error("carriage return missing after newline");

    // No new item is taken while a newline's results are pending.
    a_no_accept_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input accepted between results of one item");

    // Cursor stays on the screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (32'(o_m_axis_tdata[18:8]) < 32'(CELLS)))
        else $error("cursor position off screen");

endmodule

bind text_console_character_engine tcce_chk u_chk (.*);

`default_nettype wire

// File: verif/text_console_character_engine_test.sv
// Self-checking testbench for the text console character engine: directed table, random traffic.
module text_console_character_engine_test;
    import tcce_pkg::*;

    // Kind code the engine answers but otherwise ignores
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int ITEM_GOAL = 1850;
    localparam int PHASES    = 6;
    localparam int PRINT_CAP = 40;
    // A scrolling put reads then writes every cell above the bottom row and blanks that row, so allow a bit more
    localparam int SETTLE_CYCLES = 2 * CELLS + 100;
    localparam int DRAIN_LIMIT   = 20 * CELLS;
    // Slowest legal run: init sweep, then every item scrolling with long stalls on both sides
    localparam longint LIMIT =
        3 * (longint'(CELLS) + longint'(ITEM_GOAL + 300) * longint'(2 * CELLS + 300));

    typedef struct packed {
        logic [CHAR_W-1:0] serial_byte;
        logic              serial_valid;
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_value;
        logic              last;
    } t_console_result;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  cell_index;
        logic              typed;   // use the hand-written result instead of the predictor's
        t_console_result   want;
    } t_script_row;

    localparam t_console_result NO_WANT    = '0;
    localparam t_console_result QUIET_ZERO = '{8'h00, 1'b0, 11'd0, 16'h0000, 1'b1};
    localparam t_console_result QUIET_BLNK = '{8'h00, 1'b0, 11'd0, RESET_CELL, 1'b1};

    // Directed stimulus: reset contents, read range edges, byte extremes, backspace at
    // column 0 and at home, newline, clear, unused kind, bytes above 127.
    localparam t_script_row SCRIPT [24] = '{
        '{KIND_READ,   8'h00,        11'd0,    1'b1, QUIET_BLNK},
        '{KIND_READ,   8'hFF,        11'd1999, 1'b1, QUIET_BLNK},
        '{KIND_READ,   8'h00,        11'd2000, 1'b1, QUIET_ZERO},   // just past the store
        '{KIND_READ,   8'h00,        11'h7FF,  1'b1, QUIET_ZERO},
        '{KIND_UNUSED, 8'hFF,        11'd5,    1'b1, QUIET_ZERO},
        '{KIND_PUT,    8'h00,        11'h7FF,  1'b0, NO_WANT},
        '{KIND_PUT,    8'hFF,        11'd0,    1'b0, NO_WANT},
        '{KIND_READ,   8'h00,        11'd0,    1'b0, NO_WANT},
        '{KIND_READ,   8'h00,        11'd1,    1'b0, NO_WANT},
        '{KIND_PUT,    CH_BACKSPACE, 11'd0,    1'b0, NO_WANT},
        '{KIND_READ,   8'h00,        11'd1,    1'b0, NO_WANT},
        '{KIND_PUT,    CH_NEWLINE,   11'd0,    1'b0, NO_WANT},
        '{KIND_PUT,    CH_BACKSPACE, 11'd0,    1'b0, NO_WANT},   // at column 0 of row 1
        '{KIND_READ,   8'h00,        11'd80,   1'b0, NO_WANT},
        '{KIND_CLEAR,  8'hFF,        11'h7FF,  1'b1, QUIET_ZERO},
        '{KIND_READ,   8'h00,        11'd80,   1'b1, QUIET_BLNK},
        '{KIND_PUT,    CH_BACKSPACE, 11'd0,    1'b0, NO_WANT},   // at home
        '{KIND_PUT,    8'h41,        11'd0,    1'b0, NO_WANT},
        '{KIND_PUT,    8'h80,        11'd0,    1'b0, NO_WANT},
        '{KIND_PUT,    CH_RETURN,    11'd0,    1'b0, NO_WANT},
        '{KIND_PUT,    8'h7F,        11'd0,    1'b0, NO_WANT},
        '{KIND_READ,   8'h00,        11'd1,    1'b0, NO_WANT},
        '{KIND_READ,   8'h00,        11'd3,    1'b0, NO_WANT},
        '{KIND_UNUSED, CH_NEWLINE,   11'h7FF,  1'b0, NO_WANT}
    };

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_valid   = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data    = '0;
    logic [KIND_W-1:0]      s_user    = '0;
    logic                   m_ready   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [ATTR_W-1:0]      cfg_data  = '0;

    wire                    o_s_axis_tready;
    wire                    o_m_axis_tvalid;
    wire [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    wire [0:0]              o_m_axis_tuser;
    wire                    o_m_axis_tlast;
    wire                    o_cfg_ready;

    // Shadow copy of the console: screen, cursor and attribute register
    logic [CELL_W-1:0] shadow_screen [CELLS];
    int                shadow_row;
    int                shadow_col;
    logic [ATTR_W-1:0] shadow_attr;

    t_console_result   awaited_results [$];
    int                accepted_items;
    int                mismatch_count;
    int                send_idle_pct;
    int                sink_stall_pct;
    longint            cycle_count = 0;

    text_console_character_engine DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH cycle %0d %s: got 0x%0h, expected 0x%0h",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Apply one accepted transaction to the shadow console and queue its results.
    task automatic advance_console(input logic [KIND_W-1:0] kind,
                                   input logic [CHAR_W-1:0] ch,
                                   input logic [POS_W-1:0] idx);
        t_console_result r;
        int c;
        r = '0;
        r.last = 1'b1;
        if (kind == KIND_PUT) begin
            if (ch == CH_NEWLINE) begin
                shadow_col = 0;
                shadow_row++;
            end else if (ch == CH_BACKSPACE) begin
                if (shadow_col > 0)
                    shadow_col--;
                shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, CH_SPACE};
            end else begin
                shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, ch};
                shadow_col++;
            end
            // Wrap past the last column, then scroll past the last row
            if (shadow_col >= COLUMNS) begin
                shadow_col = 0;
                shadow_row++;
            end
            if (shadow_row >= ROWS) begin
                for (c = 0; c < CELLS - COLUMNS; c++)
                    shadow_screen[c] = shadow_screen[c + COLUMNS];
                for (c = CELLS - COLUMNS; c < CELLS; c++)
                    shadow_screen[c] = {shadow_attr, CH_SPACE};
                shadow_row = ROWS - 1;
            end
        end else if (kind == KIND_CLEAR) begin
            for (c = 0; c < CELLS; c++)
                shadow_screen[c] = {shadow_attr, CH_SPACE};
            shadow_row = 0;
            shadow_col = 0;
        end
        r.cursor_pos = POS_W'(shadow_row * COLUMNS + shadow_col);
        if (kind == KIND_PUT) begin
            r.serial_byte  = ch;
            r.serial_valid = 1'b1;
            if (ch == CH_NEWLINE) begin
                // Newline echo first, carriage return closes the item
                r.last = 1'b0;
                awaited_results.push_back(r);
                r.serial_byte = CH_RETURN;
                r.last        = 1'b1;
            end
        end else if (kind == KIND_READ) begin
            r.cell_value = (int'(idx) < CELLS) ? shadow_screen[idx] : '0;
        end
        awaited_results.push_back(r);
    endtask

    // Present one input transaction, holding valid until the engine takes it.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                             input logic [POS_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= IN_TDATA_W'({idx, ch});
        s_user  <= kind;
        @(posedge clk);
        while (!o_s_axis_tready)
            @(posedge clk);
        advance_console(kind, ch, idx);
        if (kind != KIND_UNUSED)
            accepted_items++;
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!o_cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        shadow_attr = value;
    endtask

    // Drop valid, wait for every queued result, then let the given settle time pass.
    task automatic drain_results(input int settle);
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (awaited_results.size() != 0) begin
            report_mismatch("results never delivered", awaited_results.size(), 0);
            awaited_results.delete();
        end
        repeat (settle) @(posedge clk);
    endtask

    // Random traffic built from bursts: text lines, newline runs, backspace runs,
    // reads, and now and then a clear, an unused kind or a stray byte.
    task automatic run_traffic(input int goal);
        int stop_at;
        int pick;
        int len;
        int sel;
        int i;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  idx;
        stop_at = accepted_items + goal;
        while (accepted_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 42) begin
                // Mostly short lines; about one in eight runs past the last column and wraps
                len = ($urandom_range(7) == 0) ? $urandom_range(2 * COLUMNS + 10, COLUMNS - 10)
                                               : $urandom_range(30, 1);
                for (i = 0; i < len; i++) begin
                    ch = ($urandom_range(15) == 0) ? CHAR_W'($urandom_range(255))
                                                   : CHAR_W'($urandom_range(126, 32));
                    send_item(KIND_PUT, ch, POS_W'($urandom_range(2047)));
                end
                if ($urandom_range(3) != 0)
                    send_item(KIND_PUT, CH_NEWLINE, POS_W'($urandom_range(2047)));
            end else if (pick < 52) begin
                // Long runs walk the cursor off the bottom row and force scrolls
                len = ($urandom_range(5) == 0) ? $urandom_range(ROWS + 5, ROWS - 5)
                                               : $urandom_range(6, 1);
                repeat (len) send_item(KIND_PUT, CH_NEWLINE, POS_W'($urandom_range(2047)));
            end else if (pick < 62) begin
                len = $urandom_range(12, 1);
                repeat (len) send_item(KIND_PUT, CH_BACKSPACE, POS_W'($urandom_range(2047)));
            end else if (pick < 84) begin
                len = $urandom_range(6, 1);
                for (i = 0; i < len; i++) begin
                    sel = $urandom_range(9);
                    // Favor the cursor row, where the latest writes landed
                    if (sel < 5)
                        idx = POS_W'(shadow_row * COLUMNS + $urandom_range(COLUMNS - 1));
                    else if (sel < 8)
                        idx = POS_W'($urandom_range(CELLS - 1));
                    else
                        idx = POS_W'($urandom_range(2047));
                    send_item(KIND_READ, CHAR_W'($urandom_range(255)), idx);
                end
            end else if (pick < 87) begin
                send_item(KIND_CLEAR, CHAR_W'($urandom_range(255)), POS_W'($urandom_range(2047)));
            end else if (pick < 91) begin
                send_item(KIND_UNUSED, CHAR_W'($urandom_range(255)),
                          POS_W'($urandom_range(2047)));
            end else begin
                send_item(KIND_PUT, CHAR_W'($urandom_range(255)), POS_W'($urandom_range(2047)));
            end
        end
    endtask

    // Check each result transaction against the oldest awaited result; pick the next tready.
    always @(posedge clk) begin : watch_results
        t_console_result want;
        if (rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with nothing awaited", o_m_axis_tdata, 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_m_axis_tdata[7:0] !== want.serial_byte)
                        report_mismatch("serial_byte", o_m_axis_tdata[7:0], want.serial_byte);
                    if (o_m_axis_tuser[0] !== want.serial_valid)
                        report_mismatch("serial_valid", o_m_axis_tuser[0], want.serial_valid);
                    if (o_m_axis_tdata[18:8] !== want.cursor_pos)
                        report_mismatch("cursor_pos", o_m_axis_tdata[18:8], want.cursor_pos);
                    if (o_m_axis_tdata[34:19] !== want.cell_value)
                        report_mismatch("cell_value", o_m_axis_tdata[34:19], want.cell_value);
                    if (o_m_axis_tlast !== want.last)
                        report_mismatch("last", o_m_axis_tlast, want.last);
                end
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: end the run if the engine stops taking or giving transactions
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("text_console_character_engine verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int i;
        logic [ATTR_W-1:0] attr;
        accepted_items = 0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        for (i = 0; i < CELLS; i++)
            shadow_screen[i] = RESET_CELL;
        shadow_row  = 0;
        shadow_col  = 0;
        shadow_attr = RESET_ATTR;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table runs on the reset attribute; the engine holds tready low
        // through its clearing sweep, so the first transaction simply waits.
        for (i = 0; i < $size(SCRIPT); i++) begin
            send_item(SCRIPT[i].kind, SCRIPT[i].char_code, SCRIPT[i].cell_index);
            if (SCRIPT[i].typed)
                awaited_results[awaited_results.size() - 1] = SCRIPT[i].want;
        end
        drain_results(SETTLE_CYCLES);

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 82; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 82; end
                default: begin send_idle_pct = 11; sink_stall_pct = 11; end
            endcase
            case (phase)
                0: attr = 8'hFF;
                1: attr = 8'h00;
                4: attr = 8'h80;
                default: attr = ATTR_W'($urandom_range(255));
            endcase
            write_attribute(attr);
            run_traffic(ITEM_GOAL / PHASES);
            drain_results(SETTLE_CYCLES);
        end

        if (mismatch_count == 0)
            $display("text_console_character_engine verification clean");
        else
            $display("text_console_character_engine verification failed");
        $finish;
    end

endmodule
